// ===== sv/ktct_pkg.sv =====
// package: phase codes, key codes and entry limit for the keypad thermostat cook timer
package ktct_pkg;

   typedef enum logic [1:0] {
      PH_TARGET  = 2'd0,
      PH_TIME    = 2'd1,
      PH_CONFIRM = 2'd2,
      PH_COOK    = 2'd3
   } phase_type;

   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_STAR      = 4'd10;
   localparam logic [3:0] KEY_HASH      = 4'd11;

   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam int ENTRY_DIGITS_DEFAULT = 3;
   localparam int FIELD_MAX            = 999;
   localparam int FIELD_W              = 10;
   localparam int TPH_W                = 22;
   localparam int COUNT_W              = 32;
   localparam int TEMP_W               = 12;
   localparam logic [TPH_W-1:0] TPH_RESET = 22'd720;

   // largest number of the given digit count, never above the field maximum
   function automatic int entry_limit(input int digits);
      int lim;
      lim = 1;
      for (int i = 0; i < digits && lim <= FIELD_MAX; i++) begin
         lim = lim * 10;
      end
      lim = lim - 1;
      return (lim > FIELD_MAX) ? FIELD_MAX : lim;
   endfunction

endpackage

// ===== sv/keypad_thermostat_cook_timer.sv =====
// top level: keypad set-up sequence, bang-bang heater control and cook countdown
//
// Each transfer on the req_ channel is either a key press or a timer tick with a
// water temperature sample, and gives exactly one transfer on the rsp_ channel
// showing relay drives, phase, typed entry, stored target and hours and the ticks
// left. One item is taken every cycle unless the rsp_ channel stalls; each request
// waits in the input register and its result in the result register, which is set
// by the single pass of state update logic, whose longest path is the 10 x 22 bit
// product that loads the countdown when cooking starts. A stalled rsp_ channel
// holds the result and the input register, so req_ready falls only while both
// are full. The user must write csr_ticks_per_hour only while the block is idle;
// the block does not enforce this. The value is used by the next cook started.
module keypad_thermostat_cook_timer
   import ktct_pkg::*;
#(
   parameter int ENTRY_DIGITS = ENTRY_DIGITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [3:0]                 req_key_code,
   input  logic signed [TEMP_W-1:0]   req_temperature,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_heater_on,
   output logic                       rsp_pump_on,
   output logic [1:0]                 rsp_phase,
   output logic [FIELD_W-1:0]         rsp_entry_value,
   output logic [FIELD_W-1:0]         rsp_target_celsius,
   output logic [FIELD_W-1:0]         rsp_cook_hours,
   output logic [COUNT_W-1:0]         rsp_remaining_ticks,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [TPH_W-1:0]           csr_ticks_per_hour
);

   localparam logic [FIELD_W-1:0] EntryLimit = FIELD_W'(entry_limit(ENTRY_DIGITS));

   // input register
   logic                     in_valid_ff;
   logic                     func_ff;
   logic [3:0]               key_ff;
   logic signed [TEMP_W-1:0] temp_ff;

   // block state
   phase_type                mode_ff, mode_in;
   logic [FIELD_W-1:0]       typed_ff, typed_in;
   logic                     typed_any_ff, typed_any_in;
   logic [FIELD_W-1:0]       target_ff, target_in;
   logic [FIELD_W-1:0]       hours_ff, hours_in;
   logic [COUNT_W-1:0]       countdown_ff, countdown_in;
   logic                     heater_ff, heater_in;
   logic                     pump_ff, pump_in;
   logic [TPH_W-1:0]         tph_ff;

   // result register
   logic                     out_valid_ff;

   logic                     advance;
   logic [13:0]              digit_sum;
   logic [COUNT_W-1:0]       cook_product;
   logic [COUNT_W-1:0]       count_dec;
   logic signed [14:0]       sample_ext;
   logic signed [14:0]       target_limit;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;

   assign digit_sum    = 14'(typed_ff) * 14'd10 + 14'(key_ff);
   assign cook_product = COUNT_W'(hours_ff) * COUNT_W'(tph_ff);
   assign count_dec    = (countdown_ff != '0) ? countdown_ff - 1'b1 : countdown_ff;
   assign sample_ext   = {{3{temp_ff[TEMP_W-1]}}, temp_ff};
   assign target_limit = signed'({1'b0, target_ff, 4'b0000});

   always_comb begin
      mode_in      = mode_ff;
      typed_in     = typed_ff;
      typed_any_in = typed_any_ff;
      target_in    = target_ff;
      hours_in     = hours_ff;
      countdown_in = countdown_ff;
      heater_in    = heater_ff;
      pump_in      = pump_ff;
      if (func_ff == FUNC_KEY) begin
         if (key_ff == KEY_STAR) begin
            mode_in      = PH_TARGET;
            typed_in     = '0;
            typed_any_in = 1'b0;
            target_in    = '0;
            hours_in     = '0;
            countdown_in = '0;
            heater_in    = 1'b0;
            pump_in      = 1'b0;
         end else if (mode_ff != PH_COOK) begin
            if (key_ff <= KEY_DIGIT_MAX) begin
               typed_in     = (digit_sum > 14'(EntryLimit)) ? EntryLimit
                                                           : FIELD_W'(digit_sum);
               typed_any_in = 1'b1;
            end else if (key_ff == KEY_HASH) begin
               case (mode_ff)
                  PH_TARGET, PH_TIME: begin
                     if (typed_any_ff) begin
                        typed_in     = '0;
                        typed_any_in = 1'b0;
                        if (typed_ff != '0) begin
                           if (mode_ff == PH_TARGET) begin
                              target_in = typed_ff;
                              mode_in   = PH_TIME;
                           end else begin
                              hours_in = typed_ff;
                              mode_in  = PH_CONFIRM;
                           end
                        end
                     end
                  end
                  PH_CONFIRM: begin
                     if (tph_ff != '0 && hours_ff != '0 && target_ff != '0) begin
                        countdown_in = cook_product;
                        typed_in     = '0;
                        typed_any_in = 1'b0;
                        pump_in      = 1'b1;
                        heater_in    = 1'b0;
                        mode_in      = PH_COOK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end else if (mode_ff == PH_COOK) begin
         countdown_in = count_dec;
         if (count_dec == '0) begin
            heater_in = 1'b0;
            pump_in   = 1'b0;
            mode_in   = PH_CONFIRM;
         end else begin
            heater_in = (sample_ext < target_limit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= PH_TARGET;
         typed_ff     <= '0;
         typed_any_ff <= 1'b0;
         target_ff    <= '0;
         hours_ff     <= '0;
         countdown_ff <= '0;
         heater_ff    <= 1'b0;
         pump_ff      <= 1'b0;
         tph_ff       <= TPH_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_ff      <= mode_in;
            typed_ff     <= typed_in;
            typed_any_ff <= typed_any_in;
            target_ff    <= target_in;
            hours_ff     <= hours_in;
            countdown_ff <= countdown_in;
            heater_ff    <= heater_in;
            pump_ff      <= pump_in;
         end
         if (csr_valid && csr_ready) begin
            tph_ff <= csr_ticks_per_hour;
         end
      end
   end

   // input and result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         key_ff  <= req_key_code;
         temp_ff <= req_temperature;
      end
      if (advance) begin
         rsp_heater_on       <= heater_in;
         rsp_pump_on         <= pump_in;
         rsp_phase           <= mode_in;
         rsp_entry_value     <= typed_in;
         rsp_target_celsius  <= target_in;
         rsp_cook_hours      <= hours_in;
         rsp_remaining_ticks <= (mode_in == PH_COOK) ? countdown_in : '0;
      end
   end

   // cooking always has time left
   a_cook_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == PH_COOK) |-> (countdown_ff != '0))
      else $error("cooking with an empty countdown");

   // pump runs exactly while cooking, heater never outside cooking
   a_relays: assert property (@(posedge clock) disable iff (reset)
      (pump_ff == (mode_ff == PH_COOK)) && (!heater_ff || mode_ff == PH_COOK))
      else $error("relay drive outside cooking");

   // star clears everything
   a_star: assert property (@(posedge clock) disable iff (reset)
      (advance && func_ff == FUNC_KEY && key_ff == KEY_STAR)
      |=> (mode_ff == PH_TARGET && countdown_ff == '0 && target_ff == '0))
      else $error("star did not clear the state");

   // a stalled result is not overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !advance)
      else $error("result overwritten while stalled");

endmodule

// ===== bench/cook_timer_checker.sv =====
// checker: watches the request, result and register channels, predicts each result and compares
module cook_timer_checker
   import ktct_pkg::*;
#(
   parameter int DIGITS = ENTRY_DIGITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_func,
   input  logic [3:0]               req_key_code,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     rsp_heater_on,
   input  logic                     rsp_pump_on,
   input  logic [1:0]               rsp_phase,
   input  logic [FIELD_W-1:0]       rsp_entry_value,
   input  logic [FIELD_W-1:0]       rsp_target_celsius,
   input  logic [FIELD_W-1:0]       rsp_cook_hours,
   input  logic [COUNT_W-1:0]       rsp_remaining_ticks,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [TPH_W-1:0]         csr_ticks_per_hour,
   output int                       errors,
   output int                       pending,
   output int                       checked
);

   localparam int ENTRY_CAP = (DIGITS >= 3) ? FIELD_MAX : ((DIGITS == 2) ? 99 : 9);

   typedef struct packed {
      logic               heater;
      logic               pump;
      logic [1:0]         phase;
      logic [FIELD_W-1:0] entry;
      logic [FIELD_W-1:0] target;
      logic [FIELD_W-1:0] hours;
      logic [COUNT_W-1:0] remaining;
   } cooker_view_type;

   cooker_view_type    expected_views[$];
   cooker_view_type    want;

   phase_type          mode_q;
   logic [FIELD_W-1:0] entry_q;
   logic               typed_q;
   logic [FIELD_W-1:0] target_q;
   logic [FIELD_W-1:0] hours_q;
   logic [COUNT_W-1:0] count_q;
   logic               heat_q;
   logic               pump_q;
   logic [TPH_W-1:0]   tph_q;

   int err_count = 0;
   int waiting   = 0;
   int compared  = 0;

   assign errors  = err_count;
   assign pending = waiting;
   assign checked = compared;

   task automatic clear_cooker();
      mode_q   = PH_TARGET;
      entry_q  = '0;
      typed_q  = 1'b0;
      target_q = '0;
      hours_q  = '0;
      count_q  = '0;
      heat_q   = 1'b0;
      pump_q   = 1'b0;
   endtask

   task automatic press_key(input logic [3:0] k);
      int v;
      if (k == KEY_STAR) begin
         clear_cooker();
      end else if (mode_q == PH_COOK) begin
         // only star acts while cooking
      end else if (k <= KEY_DIGIT_MAX) begin
         v = int'(entry_q) * 10 + int'(k);
         entry_q = (v > ENTRY_CAP) ? FIELD_W'(ENTRY_CAP) : FIELD_W'(v);
         typed_q = 1'b1;
      end else if (k == KEY_HASH) begin
         if (mode_q == PH_TARGET || mode_q == PH_TIME) begin
            if (typed_q) begin
               v = int'(entry_q);
               entry_q = '0;
               typed_q = 1'b0;
               if (v != 0) begin
                  if (mode_q == PH_TARGET) begin
                     target_q = FIELD_W'(v);
                     mode_q   = PH_TIME;
                  end else begin
                     hours_q = FIELD_W'(v);
                     mode_q  = PH_CONFIRM;
                  end
               end
            end
         end else if (tph_q != 0 && hours_q != 0 && target_q != 0) begin
            count_q = COUNT_W'(hours_q) * COUNT_W'(tph_q);
            entry_q = '0;
            typed_q = 1'b0;
            pump_q  = 1'b1;
            heat_q  = 1'b0;
            mode_q  = PH_COOK;
         end
      end
   endtask

   task automatic take_tick(input logic signed [TEMP_W-1:0] sample);
      if (mode_q == PH_COOK) begin
         if (count_q > 0) count_q = count_q - 1;
         if (count_q == 0) begin
            heat_q = 1'b0;
            pump_q = 1'b0;
            mode_q = PH_CONFIRM;
         end else begin
            heat_q = int'(sample) < int'(target_q) * 16;
         end
      end
   endtask

   function automatic cooker_view_type cooker_view();
      cooker_view_type v;
      v.heater    = heat_q;
      v.pump      = pump_q;
      v.phase     = mode_q;
      v.entry     = entry_q;
      v.target    = target_q;
      v.hours     = hours_q;
      v.remaining = (mode_q == PH_COOK) ? count_q : '0;
      return v;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         err_count++;
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, label, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_cooker();
         tph_q = TPH_RESET;
         expected_views.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               err_count++;
               $display("%0t result transfer with no expectation waiting", $time);
            end else begin
               want = expected_views.pop_front();
               check_field("heater_on", 32'(want.heater), 32'(rsp_heater_on));
               check_field("pump_on", 32'(want.pump), 32'(rsp_pump_on));
               check_field("phase", 32'(want.phase), 32'(rsp_phase));
               check_field("entry_value", 32'(want.entry), 32'(rsp_entry_value));
               check_field("target_celsius", 32'(want.target), 32'(rsp_target_celsius));
               check_field("cook_hours", 32'(want.hours), 32'(rsp_cook_hours));
               check_field("remaining_ticks", want.remaining, rsp_remaining_ticks);
               compared++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_func == FUNC_KEY) press_key(req_key_code);
            else take_tick(req_temperature);
            expected_views.push_back(cooker_view());
         end
         if (csr_valid && csr_ready) tph_q = csr_ticks_per_hour;
      end
      waiting <= expected_views.size();
   end

endmodule

// ===== bench/tb.sv =====
// testbench top: clock, reset, stimulus for the keypad thermostat cook timer and the verdict
module tb;
   import ktct_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int          PHASE_ITEMS  = 160;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_func = FUNC_KEY;
   logic [3:0]               req_key_code = '0;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_heater_on;
   logic                     rsp_pump_on;
   logic [1:0]               rsp_phase;
   logic [FIELD_W-1:0]       rsp_entry_value;
   logic [FIELD_W-1:0]       rsp_target_celsius;
   logic [FIELD_W-1:0]       rsp_cook_hours;
   logic [COUNT_W-1:0]       rsp_remaining_ticks;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [TPH_W-1:0]         csr_ticks_per_hour = '0;

   int          errors;
   int          pending;
   int          checked;
   int          send_idle = 0;
   int          rsp_stall = 0;
   int          sent = 0;
   int          settings = 0;
   int unsigned cycle_count = 0;
   int unsigned tph_list [8] = '{1, 3600000, 5, 720, 2, 4194303, 0, 3};

   keypad_thermostat_cook_timer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_key_code       (req_key_code),
      .req_temperature    (req_temperature),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_heater_on      (rsp_heater_on),
      .rsp_pump_on        (rsp_pump_on),
      .rsp_phase          (rsp_phase),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_target_celsius (rsp_target_celsius),
      .rsp_cook_hours     (rsp_cook_hours),
      .rsp_remaining_ticks(rsp_remaining_ticks),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_ticks_per_hour (csr_ticks_per_hour)
   );

   cook_timer_checker cook_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_key_code       (req_key_code),
      .req_temperature    (req_temperature),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_heater_on      (rsp_heater_on),
      .rsp_pump_on        (rsp_pump_on),
      .rsp_phase          (rsp_phase),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_target_celsius (rsp_target_celsius),
      .rsp_cook_hours     (rsp_cook_hours),
      .rsp_remaining_ticks(rsp_remaining_ticks),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_ticks_per_hour (csr_ticks_per_hour),
      .errors             (errors),
      .pending            (pending),
      .checked            (checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int rand_temp();
      return int'($urandom_range(0, 2880)) - 880;
   endfunction

   function automatic int near_temp(input int unsigned tgt);
      int v;
      v = int'(tgt) * 16 + int'($urandom_range(0, 80)) - 40;
      if (v > 2000) v = 2000;
      if (v < -880) v = -880;
      return v;
   endfunction

   task automatic send(input logic f, input logic [3:0] k, input int t);
      if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_key_code    <= k;
      req_temperature <= t[TEMP_W-1:0];
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic key(input logic [3:0] k);
      send(FUNC_KEY, k, rand_temp());
   endtask

   task automatic tick(input int t);
      send(FUNC_TICK, 4'($urandom_range(0, 15)), t);
   endtask

   // hold the sender off until every result has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tph(input int unsigned v);
      settle();
      csr_valid          <= 1'b1;
      csr_ticks_per_hour <= v[TPH_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic type_number(input int unsigned value);
      int unsigned div;
      div = 1;
      while (div * 10 <= value) div = div * 10;
      while (div > 0) begin
         key(4'((value / div) % 10));
         div = div / 10;
      end
   endtask

   task automatic cook_session();
      int unsigned tgt;
      int unsigned hrs;
      key(KEY_STAR);
      case ($urandom_range(0, 9))
         0:       tgt = $urandom_range(0, 999);
         1:       tgt = $urandom_range(1000, 99999);
         default: tgt = $urandom_range(1, 125);
      endcase
      if ($urandom_range(0, 9) == 0) key(4'd0);
      type_number(tgt);
      key(KEY_HASH);
      hrs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999) : $urandom_range(1, 3);
      type_number(hrs);
      key(KEY_HASH);
      if ($urandom_range(0, 5) == 0) key(4'($urandom_range(0, 9)));
      key(KEY_HASH);
      repeat ($urandom_range(1, 20)) begin
         case ($urandom_range(0, 15))
            0:       key(4'($urandom_range(0, 15)));
            1:       tick(rand_temp());
            default: tick(near_temp(tgt));
         endcase
      end
      if ($urandom_range(0, 3) == 0) begin
         key(KEY_HASH);
         repeat ($urandom_range(1, 6)) tick(near_temp(tgt));
      end
      if ($urandom_range(0, 2) == 0) key(KEY_STAR);
   endtask

   initial begin
      int start;
      bit paused;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // set-up corner cases with no ticks per hour
      write_tph(0);
      key(KEY_HASH);
      key(4'd12);
      tick(-880);
      key(4'd0);
      key(KEY_HASH);
      key(4'd9); key(4'd9); key(4'd9); key(4'd9);
      key(KEY_HASH);
      key(4'd1);
      key(KEY_HASH);
      key(4'd5);
      key(KEY_HASH);
      key(KEY_STAR);

      // short cook: ignored keys, heater either side of target, end and abort
      write_tph(1);
      key(4'd2); key(4'd5);
      key(KEY_HASH);
      key(4'd3);
      key(KEY_HASH);
      key(KEY_HASH);
      key(4'd7);
      key(KEY_HASH);
      key(4'd15);
      tick(399);
      tick(400);
      tick(2000);
      key(KEY_HASH);
      tick(-880);
      key(KEY_STAR);

      for (int ph = 0; ph < 8; ph++) begin
         write_tph(tph_list[ph]);
         case (ph % 4)
            0: begin send_idle = 0;  rsp_stall = 0;  end
            1: begin send_idle = 53; rsp_stall = 0;  end
            2: begin send_idle = 0;  rsp_stall = 53; end
            default: begin send_idle = 23; rsp_stall = 23; end
         endcase
         start  = sent;
         paused = 1'b0;
         while (sent - start < PHASE_ITEMS) begin
            if (!paused && sent - start >= PHASE_ITEMS / 2) begin
               settle();
               paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 6))
                  send(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_temp());
            end else begin
               cook_session();
            end
         end
      end

      send_idle = 0;
      rsp_stall = 0;
      settle();
      repeat (8) @(posedge clock);
      $display("run covered %0d request transfers under %0d ticks-per-hour settings,",
               sent, settings);
      $display("with idle and stall phases, %0d results compared", checked);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
